/* rtl/sliding_window_min_max_avg_top_defines.svh */
// Assertion macros for the sliding window statistics block.
// Used by sliding_window_min_max_avg_top, which carries concurrent assertions; no other dependencies.
`ifndef SLIDING_WINDOW_MIN_MAX_AVG_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_AVG_TOP_DEFINES_SVH

`ifndef SYNTH
// Checked on every rising clock edge, switched off while reset is asserted.
`define SWMMA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define SWMMA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWMMA_ASSERT_RST(label, prop, msg)
`define SWMMA_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* rtl/swmma_pkg.sv */
// Shared types and constants for the sliding window statistics block.
// No dependencies; imported by sliding_window_min_max_avg_top.
`default_nettype none

package swmma_pkg;

  // Default window depth and fixed field widths.
  localparam int unsigned WINDOW_DEF = 128;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned FILLED_W   = 8;

  // Item mode codes.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  // Input item.
  typedef struct packed {
    logic                mode;
    logic [SAMPLE_W-1:0] sample_mv;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic                have_data;
    logic [SAMPLE_W-1:0] min_mv;
    logic [SAMPLE_W-1:0] max_mv;
    logic [SAMPLE_W-1:0] avg_mv;
    logic [FILLED_W-1:0] filled;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } seq_state_t;

endpackage

`default_nettype wire

/* rtl/sliding_window_min_max_avg_top.sv */
// Items are handled one at a time. For each, the history memory is scanned (one entry
// a cycle) over fill entries (fill = samples in the window after the item), then the
// bit-serial divider (one quotient bit a cycle) runs over SUM_W bits (SUM_W = 12 + bits
// of the fill count); an empty window skips both scan and divide.
// Reset: synchronous, active low; clears position, fill count, scan index, read valid, pause, state and output valid.
// The history memory is not cleared; only written entries are ever read.
`default_nettype none

`include "sliding_window_min_max_avg_top_defines.svh"

module sliding_window_min_max_avg_top #(
  parameter int unsigned WINDOW = swmma_pkg::WINDOW_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input channel.
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire swmma_pkg::in_item_t  in_item,
  // Result channel.
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      swmma_pkg::out_item_t out_item,
  // Configuration: pause register.
  input  wire logic                 cfg_wr_en,
  input  wire logic                 cfg_wr_data
);

  import swmma_pkg::*;

  localparam int unsigned ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + FILL_W;
  localparam int unsigned REM_W  = FILL_W + 1;
  localparam int unsigned CNT_W  = $clog2(SUM_W + 1);

  // History memory.
  logic [SAMPLE_W-1:0] mem [WINDOW];

  seq_state_t          state_r, state_nxt;
  logic                paused_r, paused_nxt;
  logic [ADDR_W-1:0]   wp_r, wp_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [FILL_W-1:0]   idx_r, idx_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [SAMPLE_W-1:0] rdata_r;
  logic [SAMPLE_W-1:0] min_r, min_nxt;
  logic [SAMPLE_W-1:0] max_r, max_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    div_cnt_r, div_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  logic                accept;
  logic                wr_en;
  logic                rd_issue;
  logic                scan_done;
  logic                div_last;
  logic                out_load;
  logic [FILL_W-1:0]   fill_upd;
  logic [REM_W-1:0]    rem_sh;
  logic                rem_ge;
  logic                have_data;

  // Handshake, write decode and sequencer conditions.
  assign accept    = in_valid && !in_stall;
  assign wr_en     = accept && (in_item.mode == MODE_SAMPLE) && !paused_r;
  assign scan_done = (idx_r == fill_r) && !rd_vld_r;
  assign div_last  = (div_cnt_r == CNT_W'(SUM_W - 1));

  // Fill count as it stands after the item being accepted.
  always_comb begin
    fill_upd = fill_r;
    if (in_item.mode == MODE_CLEAR) begin
      fill_upd = '0;
    end else if (!paused_r && (fill_r != FILL_W'(WINDOW))) begin
      fill_upd = fill_r + FILL_W'(1);
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (fill_upd == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall = 1'b1;
    rd_issue = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_SCAN: rd_issue = (idx_r != fill_r);
      ST_DIV:  rd_issue = 1'b0;
      ST_DONE: out_load = !out_valid_r || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh = {rem_r[REM_W-2:0], sum_r[SUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, fill_r});
  assign have_data = (fill_r != '0);

  // Datapath next values.
  always_comb begin
    paused_nxt    = paused_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    rd_vld_nxt    = rd_issue;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    if (cfg_wr_en) begin
      paused_nxt = cfg_wr_data;
    end

    // Item arrival: update the ring pointers and start a fresh scan.
    if (accept) begin
      fill_nxt = fill_upd;
      if (in_item.mode == MODE_CLEAR) begin
        wp_nxt = '0;
      end else if (!paused_r) begin
        wp_nxt = (wp_r == ADDR_W'(WINDOW - 1)) ? '0 : wp_r + ADDR_W'(1);
      end
      idx_nxt = '0;
      min_nxt = '1;
      max_nxt = '0;
      sum_nxt = '0;
    end

    // Scan: one read issued and one entry folded in per cycle.
    if (rd_issue) begin
      idx_nxt = idx_r + FILL_W'(1);
    end
    if (rd_vld_r) begin
      if (rdata_r < min_r) begin
        min_nxt = rdata_r;
      end
      if (rdata_r > max_r) begin
        max_nxt = rdata_r;
      end
      sum_nxt = sum_r + SUM_W'(rdata_r);
    end
    if ((state_r == ST_SCAN) && scan_done) begin
      rem_nxt     = '0;
      div_cnt_nxt = '0;
    end

    // Divide: the sum register shifts into the quotient.
    if (state_r == ST_DIV) begin
      rem_nxt     = rem_ge ? (rem_sh - {1'b0, fill_r}) : rem_sh;
      sum_nxt     = {sum_r[SUM_W-2:0], rem_ge};
      div_cnt_nxt = div_cnt_r + CNT_W'(1);
    end

    // Result register.
    if (out_load) begin
      out_valid_nxt          = 1'b1;
      out_item_nxt.have_data = have_data;
      out_item_nxt.min_mv    = have_data ? min_r : '0;
      out_item_nxt.max_mv    = have_data ? max_r : '0;
      out_item_nxt.avg_mv    = have_data ? sum_r[SAMPLE_W-1:0] : '0;
      out_item_nxt.filled    = FILLED_W'(fill_r);
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      paused_r    <= 1'b0;
      wp_r        <= '0;
      fill_r      <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      paused_r    <= paused_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    min_r      <= min_nxt;
    max_r      <= max_nxt;
    sum_r      <= sum_nxt;
    rem_r      <= rem_nxt;
    div_cnt_r  <= div_cnt_nxt;
    out_item_r <= out_item_nxt;
  end

  // History memory write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= in_item.sample_mv;
    end
  end

  // History memory read port, registered data.
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rdata_r <= mem[idx_r[ADDR_W-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The fill count never passes the window depth.
  `SWMMA_ASSERT_RST(a_fill_bound, fill_r <= FILL_W'(WINDOW), "fill count above window depth")
  // Until the ring wraps, the write position tracks the fill count.
  `SWMMA_ASSERT_RST(a_wp_tracks_fill, (fill_r < FILL_W'(WINDOW)) |-> (FILL_W'(wp_r) == fill_r), "write position out of step with fill count")
  // An accepted item always starts work.
  `SWMMA_ASSERT_RST(a_accept_busy, accept |=> (state_r != ST_IDLE), "item accepted but sequencer stayed idle")
  // The divider only runs after the whole window has been scanned.
  `SWMMA_ASSERT_RST(a_div_after_scan, (state_r == ST_DIV) |-> ((idx_r == fill_r) && !rd_vld_r), "division started before scan completed")
  // The mean lies between the minimum and the maximum.
  `SWMMA_ASSERT_RST(a_avg_range, (out_valid_r && out_item_r.have_data) |-> ((out_item_r.avg_mv >= out_item_r.min_mv) && (out_item_r.avg_mv <= out_item_r.max_mv)), "mean outside min and max")

endmodule

`default_nettype wire
